// File: design/assert_macros.svh
// assertion macros used by the checker file of the obb block
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define OBB_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (prop)) \
        else $error("obb assertion failed");

// expression must never be true outside reset
`define OBB_NEVER(label, clk_sig, rst_sig, expr) \
    `OBB_ASSERT(label, clk_sig, rst_sig, !(expr))

`endif

// File: design/obb_pkg.sv
// shared types, register indexes and helper functions of the obb block
// no dependencies; imported by every obb module and the checker
package obb_pkg;

    // config port
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_CTR_X    = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] REG_CTR_Y    = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] REG_X_AXIS_X = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] REG_X_AXIS_Y = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] REG_Y_AXIS_X = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] REG_Y_AXIS_Y = CfgIdxW'(5);
    localparam logic [CfgIdxW-1:0] REG_HALF_X   = CfgIdxW'(6);
    localparam logic [CfgIdxW-1:0] REG_HALF_Y   = CfgIdxW'(7);

    // datapath stages
    localparam int NumStages = 6;

    localparam logic [47:0] DistMax  = '1;
    localparam logic [48:0] RoundQ14 = 49'd16383;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } point_t;

    typedef struct packed {
        logic        [47:0] sq_distance;
        logic               distance_saturated;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_y;
        logic               box_saturated;
    } result_t;

    typedef struct packed {
        logic signed [31:0] ctr_x;
        logic signed [31:0] ctr_y;
        logic signed [15:0] x_axis_x;
        logic signed [15:0] x_axis_y;
        logic signed [15:0] y_axis_x;
        logic signed [15:0] y_axis_y;
        logic        [30:0] half_x;
        logic        [30:0] half_y;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic               saturated;
    } box_t;

    localparam cfg_t CfgReset = '{
        ctr_x:    32'sd0,
        ctr_y:    32'sd0,
        x_axis_x: 16'sd16384,
        x_axis_y: 16'sd0,
        y_axis_x: 16'sd0,
        y_axis_y: 16'sd16384,
        half_x:   31'd0,
        half_y:   31'd0
    };

    // magnitude of a Q1.14 axis component, -32768 maps to 32768
    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    // magnitude of a projection
    function automatic logic [35:0] abs36(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    // bound leaves the signed 32-bit range
    function automatic logic ovf37(input logic signed [36:0] v);
        return !((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111));
    endfunction

    // bound clipped to the signed 32-bit range
    function automatic logic [31:0] clip37(input logic signed [36:0] v);
        logic [31:0] r;
        if (ovf37(v))
        begin
            r = v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/obb_cfg_regs.sv
// rectangle configuration registers of the obb block
// depends on obb_pkg
module obb_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [obb_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [obb_pkg::CfgDataW-1:0]  cfg_data,
    output obb_pkg::cfg_t                 cfg
);
    import obb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register write decode, unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CTR_X:    cfg_next.ctr_x    = cfg_data;
                REG_CTR_Y:    cfg_next.ctr_y    = cfg_data;
                REG_X_AXIS_X: cfg_next.x_axis_x = cfg_data[15:0];
                REG_X_AXIS_Y: cfg_next.x_axis_y = cfg_data[15:0];
                REG_Y_AXIS_X: cfg_next.y_axis_x = cfg_data[15:0];
                REG_Y_AXIS_Y: cfg_next.y_axis_y = cfg_data[15:0];
                REG_HALF_X:   cfg_next.half_x   = cfg_data[30:0];
                REG_HALF_Y:   cfg_next.half_y   = cfg_data[30:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/obb_skid.sv
// two-entry output buffer of the obb block, registered ready toward the pipeline
// depends on obb_pkg
module obb_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  obb_pkg::result_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output obb_pkg::result_t out_item
);
    import obb_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_item_reg;
    result_t out_item_next;
    result_t skid_item_reg;
    result_t skid_item_next;
    logic    in_acc;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;

    // output slot refills from the skid entry first, else from the input
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_acc;
                out_item_next  = in_item;
            end
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: design/obb_pipe.sv
// six-stage datapath of the obb block: projection, excess squares, box bounds
// depends on obb_pkg
module obb_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  obb_pkg::point_t  point,
    input  obb_pkg::cfg_t    cfg,
    output logic             res_valid,
    input  logic             res_ready,
    output obb_pkg::result_t res
);
    import obb_pkg::*;

    // stage control
    logic [NumStages-1:0] vld_reg;
    logic [NumStages-1:0] vld_next;
    logic [NumStages-1:0] adv;

    // stage 1: offset from center, box products
    logic signed [32:0] s1_dx_reg,  s1_dx_next;
    logic signed [32:0] s1_dy_reg,  s1_dy_next;
    logic        [46:0] s1_bx0_reg, s1_bx0_next;
    logic        [46:0] s1_bx1_reg, s1_bx1_next;
    logic        [46:0] s1_by0_reg, s1_by0_next;
    logic        [46:0] s1_by1_reg, s1_by1_next;

    // stage 2: projection products, box half widths
    logic signed [48:0] s2_pxx_reg, s2_pxx_next;
    logic signed [48:0] s2_pxy_reg, s2_pxy_next;
    logic signed [48:0] s2_pyx_reg, s2_pyx_next;
    logic signed [48:0] s2_pyy_reg, s2_pyy_next;
    logic        [34:0] s2_wx_reg,  s2_wx_next;
    logic        [34:0] s2_wy_reg,  s2_wy_next;
    logic        [48:0] s2_wsum_x;
    logic        [48:0] s2_wsum_y;

    // stage 3: projections, box bounds
    logic signed [35:0] s3_tx_reg,  s3_tx_next;
    logic signed [35:0] s3_ty_reg,  s3_ty_next;
    box_t               s3_box_reg, s3_box_next;
    logic signed [49:0] s3_sum_x;
    logic signed [49:0] s3_sum_y;
    logic signed [36:0] s3_cx_ext, s3_cy_ext, s3_wx_ext, s3_wy_ext;
    logic signed [36:0] s3_lo_x, s3_hi_x, s3_lo_y, s3_hi_y;

    // stage 4: excess beyond half extents
    logic        [31:0] s4_ex_reg,  s4_ex_next;
    logic        [31:0] s4_ey_reg,  s4_ey_next;
    logic               s4_ovf_reg, s4_ovf_next;
    box_t               s4_box_reg;
    logic        [35:0] s4_ax, s4_ay, s4_hx, s4_hy, s4_ex_w, s4_ey_w;

    // stage 5: squared excess
    logic        [47:0] s5_sqx_reg, s5_sqx_next;
    logic        [47:0] s5_sqy_reg, s5_sqy_next;
    logic               s5_ovf_reg;
    box_t               s5_box_reg;

    // stage 6: saturating sum, result
    result_t            s6_res_reg, s6_res_next;
    logic        [48:0] s6_sum;
    logic               s6_sat;

    // a stage loads when empty or when its item moves on
    always_comb
    begin
        adv[NumStages-1] = !vld_reg[NumStages-1] || res_ready;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = point_valid;
        end
        for (int k = 1; k < NumStages; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign point_ready = adv[0];
    assign res_valid   = vld_reg[NumStages-1];
    assign res         = s6_res_reg;

    // stage 1 logic
    always_comb
    begin
        s1_dx_next  = 33'(point.point_x) - 33'(cfg.ctr_x);
        s1_dy_next  = 33'(point.point_y) - 33'(cfg.ctr_y);
        s1_bx0_next = 47'(abs16(cfg.x_axis_x)) * 47'(cfg.half_x);
        s1_bx1_next = 47'(abs16(cfg.y_axis_x)) * 47'(cfg.half_y);
        s1_by0_next = 47'(abs16(cfg.x_axis_y)) * 47'(cfg.half_x);
        s1_by1_next = 47'(abs16(cfg.y_axis_y)) * 47'(cfg.half_y);
    end

    // stage 2 logic, half widths rounded up from Q16.30
    always_comb
    begin
        s2_pxx_next = 49'(s1_dx_reg) * 49'(cfg.x_axis_x);
        s2_pxy_next = 49'(s1_dy_reg) * 49'(cfg.x_axis_y);
        s2_pyx_next = 49'(s1_dx_reg) * 49'(cfg.y_axis_x);
        s2_pyy_next = 49'(s1_dy_reg) * 49'(cfg.y_axis_y);
        s2_wsum_x   = 49'(s1_bx0_reg) + 49'(s1_bx1_reg) + RoundQ14;
        s2_wsum_y   = 49'(s1_by0_reg) + 49'(s1_by1_reg) + RoundQ14;
        s2_wx_next  = s2_wsum_x[48:14];
        s2_wy_next  = s2_wsum_y[48:14];
    end

    // stage 3 logic, floor by dropping the low 14 bits
    always_comb
    begin
        s3_sum_x   = 50'(s2_pxx_reg) + 50'(s2_pxy_reg);
        s3_sum_y   = 50'(s2_pyx_reg) + 50'(s2_pyy_reg);
        s3_tx_next = s3_sum_x[49:14];
        s3_ty_next = s3_sum_y[49:14];

        s3_cx_ext = 37'(cfg.ctr_x);
        s3_cy_ext = 37'(cfg.ctr_y);
        s3_wx_ext = 37'(s2_wx_reg);
        s3_wy_ext = 37'(s2_wy_reg);
        s3_lo_x   = s3_cx_ext - s3_wx_ext;
        s3_hi_x   = s3_cx_ext + s3_wx_ext;
        s3_lo_y   = s3_cy_ext - s3_wy_ext;
        s3_hi_y   = s3_cy_ext + s3_wy_ext;

        s3_box_next.min_x     = clip37(s3_lo_x);
        s3_box_next.max_x     = clip37(s3_hi_x);
        s3_box_next.min_y     = clip37(s3_lo_y);
        s3_box_next.max_y     = clip37(s3_hi_y);
        s3_box_next.saturated = ovf37(s3_lo_x) || ovf37(s3_hi_x)
                             || ovf37(s3_lo_y) || ovf37(s3_hi_y);
    end

    // stage 4 logic, excess of 2^32 or more forces saturation
    always_comb
    begin
        s4_ax   = abs36(s3_tx_reg);
        s4_ay   = abs36(s3_ty_reg);
        s4_hx   = 36'(cfg.half_x);
        s4_hy   = 36'(cfg.half_y);
        s4_ex_w = (s4_ax > s4_hx) ? (s4_ax - s4_hx) : '0;
        s4_ey_w = (s4_ay > s4_hy) ? (s4_ay - s4_hy) : '0;
        s4_ex_next  = s4_ex_w[31:0];
        s4_ey_next  = s4_ey_w[31:0];
        s4_ovf_next = (s4_ex_w[35:32] != 4'd0) || (s4_ey_w[35:32] != 4'd0);
    end

    // stage 5 logic, squares back to Q32.16
    always_comb
    begin
        s5_sqx_next = 48'((64'(s4_ex_reg) * 64'(s4_ex_reg)) >> 16);
        s5_sqy_next = 48'((64'(s4_ey_reg) * 64'(s4_ey_reg)) >> 16);
    end

    // stage 6 logic
    always_comb
    begin
        s6_sum = 49'(s5_sqx_reg) + 49'(s5_sqy_reg);
        s6_sat = s5_ovf_reg || s6_sum[48];
        s6_res_next.sq_distance        = s6_sat ? DistMax : s6_sum[47:0];
        s6_res_next.distance_saturated = s6_sat;
        s6_res_next.box_min_x          = s5_box_reg.min_x;
        s6_res_next.box_max_x          = s5_box_reg.max_x;
        s6_res_next.box_min_y          = s5_box_reg.min_y;
        s6_res_next.box_max_y          = s5_box_reg.max_y;
        s6_res_next.box_saturated      = s5_box_reg.saturated;
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_bx0_reg <= s1_bx0_next;
            s1_bx1_reg <= s1_bx1_next;
            s1_by0_reg <= s1_by0_next;
            s1_by1_reg <= s1_by1_next;
        end
        if (adv[1])
        begin
            s2_pxx_reg <= s2_pxx_next;
            s2_pxy_reg <= s2_pxy_next;
            s2_pyx_reg <= s2_pyx_next;
            s2_pyy_reg <= s2_pyy_next;
            s2_wx_reg  <= s2_wx_next;
            s2_wy_reg  <= s2_wy_next;
        end
        if (adv[2])
        begin
            s3_tx_reg  <= s3_tx_next;
            s3_ty_reg  <= s3_ty_next;
            s3_box_reg <= s3_box_next;
        end
        if (adv[3])
        begin
            s4_ex_reg  <= s4_ex_next;
            s4_ey_reg  <= s4_ey_next;
            s4_ovf_reg <= s4_ovf_next;
            s4_box_reg <= s3_box_reg;
        end
        if (adv[4])
        begin
            s5_sqx_reg <= s5_sqx_next;
            s5_sqy_reg <= s5_sqy_next;
            s5_ovf_reg <= s4_ovf_reg;
            s5_box_reg <= s4_box_reg;
        end
        if (adv[5])
        begin
            s6_res_reg <= s6_res_next;
        end
    end

endmodule

// File: design/obb_point_distance_and_bounds_core.sv
// top level of the oriented rectangle point distance and bounds block
// depends on obb_pkg, obb_cfg_regs, obb_pipe, obb_skid

// Takes one point item per clock while point_ready is high and returns one result
// item per point, in order. A result passes through six datapath stages (center
// offset and box products, projection products, projection and box clipping,
// excess, square, saturating sum) and the output register of a two-entry output
// buffer. With result_ready held high the sustained rate is one item per cycle.
// While a finished result waits, points are still taken until the six stages and
// the buffer hold eight items. The rectangle is set through the cfg port, which is
// always ready; write it only while no item is in flight. Indexes beyond the
// eight registers are ignored.
module obb_point_distance_and_bounds_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [obb_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [obb_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          point_valid,
    output logic                          point_ready,
    input  obb_pkg::point_t               point,
    output logic                          result_valid,
    input  logic                          result_ready,
    output obb_pkg::result_t              result
);
    import obb_pkg::*;

    cfg_t    cfg;
    logic    pipe_valid;
    logic    pipe_ready;
    result_t pipe_res;

    // rectangle registers
    obb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // datapath
    obb_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .cfg         (cfg),
        .res_valid   (pipe_valid),
        .res_ready   (pipe_ready),
        .res         (pipe_res)
    );

    // output buffer
    obb_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid),
        .in_ready  (pipe_ready),
        .in_item   (pipe_res),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (result)
    );

endmodule

// File: design/obb_checker.sv
// port-level assertions of the obb block, bound to the top level
// depends on obb_pkg and assert_macros.svh
`include "assert_macros.svh"

module obb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          point_valid,
    input logic                          point_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input obb_pkg::result_t              result
);
    import obb_pkg::*;

    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;
    logic       pt_acc;
    logic       res_acc;
    logic       res_stall;
    logic       x_ordered;
    logic       y_ordered;

    assign pt_acc    = point_valid && point_ready;
    assign res_acc   = result_valid && result_ready;
    assign res_stall = result_valid && !result_ready;
    assign x_ordered = result.box_min_x <= result.box_max_x;
    assign y_ordered = result.box_min_y <= result.box_max_y;

    // items accepted but not yet delivered
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (pt_acc && !res_acc)
        begin
            outstanding_next = outstanding_reg + 4'd1;
        end
        else if (!pt_acc && res_acc)
        begin
            outstanding_next = outstanding_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // stalled result holds
    `OBB_ASSERT(a_result_hold, clk, rst_n, res_stall |=> result_valid && $stable(result))

    // no result without an item behind it
    `OBB_NEVER(a_no_phantom, clk, rst_n, result_valid && (outstanding_reg == 4'd0))

    // saturated distance reads as full scale
    `OBB_ASSERT(a_dist_sat, clk, rst_n, res_acc && result.distance_saturated |-> result.sq_distance == DistMax)

    // unclipped box is ordered
    `OBB_ASSERT(a_box_order, clk, rst_n, res_acc && !result.box_saturated |-> x_ordered && y_ordered)

endmodule

bind obb_point_distance_and_bounds_core obb_checker u_obb_checker (.*);
